/* hw/rtl/lenient_utf8_decoder_core_macros.svh */
// Assertion macros used by the decoder core.
`ifndef LENIENT_UTF8_DECODER_CORE_MACROS_SVH
`define LENIENT_UTF8_DECODER_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define LUD_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define LUD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/lud_pkg.sv */
`timescale 1ns / 1ps

package lud_pkg;

   localparam int IndexBits = 16;
   localparam int CpBits    = 21;
   localparam int IdxOutBits = 16;

   localparam logic [IndexBits-1:0] IndexMax = '1;

   // Sequence lengths as taken from the masked top bits of a lead byte.
   localparam logic [2:0] LenStray = 3'd0;
   localparam logic [2:0] LenOne   = 3'd1;
   localparam logic [2:0] LenTwo   = 3'd2;
   localparam logic [2:0] LenThree = 3'd3;
   localparam logic [2:0] LenFour  = 3'd4;

   typedef struct packed {
      logic [CpBits-1:0]     code_point;
      logic                  point_valid;
      logic [IdxOutBits-1:0] point_index;
      logic                  end_of_string;
      logic                  last_of_run;
   } res_type;

   // Up to two results come from one byte; count is 0, 1 or 2.
   typedef struct packed {
      res_type    r0;
      res_type    r1;
      logic [1:0] count;
   } pair_type;

   typedef struct packed {
      logic [2:0][7:0]       held;
      logic [1:0]            held_count;
      logic [2:0]            seq_len;
      logic [IndexBits-1:0]  counter;
   } state_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if ((b & 8'h80) == 8'h00) len = LenOne;
      else if ((b & 8'hE0) == 8'hC0) len = LenTwo;
      else if ((b & 8'hF0) == 8'hE0) len = LenThree;
      else if ((b & 8'hF8) == 8'hF0) len = LenFour;
      else len = LenStray;
      return len;
   endfunction

   function automatic logic [IndexBits-1:0] sat_inc(input logic [IndexBits-1:0] c);
      logic [IndexBits-1:0] r;
      if (c == IndexMax) r = c;
      else r = c + 1'b1;
      return r;
   endfunction

endpackage

/* hw/rtl/lud_decode.sv */
`timescale 1ns / 1ps

module lud_decode (
   input  lud_pkg::state_type cur_state,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   output lud_pkg::state_type nxt_state,
   output lud_pkg::pair_type  pair
);

   logic [lud_pkg::CpBits-1:0]    cp_a;
   logic [lud_pkg::CpBits-1:0]    cp_b;
   logic [lud_pkg::CpBits-1:0]    cp_full;
   logic                          va;
   logic                          vb;
   logic [2:0]                    len;
   logic [7:0]                    tx;
   logic [lud_pkg::IndexBits-1:0] ctr1;
   logic [lud_pkg::IndexBits-1:0] ctr2;

   assign len = lud_pkg::lead_len(data_byte);
   assign tx  = cur_state.held[1];

   always_comb begin
      unique case (cur_state.seq_len)
         lud_pkg::LenTwo:
            cp_full = {10'd0, cur_state.held[0][4:0], data_byte[5:0]};
         lud_pkg::LenThree:
            cp_full = {5'd0, cur_state.held[0][3:0], cur_state.held[1][5:0], data_byte[5:0]};
         default:
            cp_full = {cur_state.held[0][2:0], cur_state.held[1][5:0],
                       cur_state.held[2][5:0], data_byte[5:0]};
      endcase
   end

   always_comb begin
      va        = 1'b0;
      vb        = 1'b0;
      cp_a      = '0;
      cp_b      = '0;
      nxt_state = cur_state;
      if (cur_state.seq_len == lud_pkg::LenStray) begin
         if (len == lud_pkg::LenOne) begin
            va   = 1'b1;
            cp_a = {13'd0, data_byte};
         end else if (len >= lud_pkg::LenTwo && !last_byte) begin
            nxt_state.held[0]    = data_byte;
            nxt_state.held_count = 2'd1;
            nxt_state.seq_len    = len;
         end
      end else if ({1'b0, cur_state.held_count} + 3'd1 >= cur_state.seq_len) begin
         va                   = 1'b1;
         cp_a                 = cp_full;
         nxt_state.held_count = 2'd0;
         nxt_state.seq_len    = lud_pkg::LenStray;
      end else if (last_byte) begin
         // Truncated sequence: drop the lead and decode what follows it afresh.
         if (cur_state.held_count == 2'd1) begin
            va   = !data_byte[7];
            cp_a = {13'd0, data_byte};
         end else if (!tx[7]) begin
            va   = 1'b1;
            cp_a = {13'd0, tx};
            vb   = !data_byte[7];
            cp_b = {13'd0, data_byte};
         end else if (lud_pkg::lead_len(tx) == lud_pkg::LenTwo) begin
            va   = 1'b1;
            cp_a = {10'd0, tx[4:0], data_byte[5:0]};
         end else begin
            va   = !data_byte[7];
            cp_a = {13'd0, data_byte};
         end
      end else begin
         nxt_state.held[cur_state.held_count] = data_byte;
         nxt_state.held_count = cur_state.held_count + 2'd1;
      end
      ctr1 = va ? lud_pkg::sat_inc(cur_state.counter) : cur_state.counter;
      ctr2 = vb ? lud_pkg::sat_inc(ctr1) : ctr1;
      if (last_byte) begin
         nxt_state = '0;
      end else begin
         nxt_state.counter = ctr2;
      end
   end

   always_comb begin
      pair.r0.code_point    = va ? cp_a : '0;
      pair.r0.point_valid   = va;
      pair.r0.point_index   = lud_pkg::IdxOutBits'(cur_state.counter);
      pair.r0.end_of_string = last_byte && !vb;
      pair.r0.last_of_run   = !vb;
      pair.r1.code_point    = vb ? cp_b : '0;
      pair.r1.point_valid   = vb;
      pair.r1.point_index   = lud_pkg::IdxOutBits'(ctr1);
      pair.r1.end_of_string = last_byte;
      pair.r1.last_of_run   = 1'b1;
      if (vb) pair.count = 2'd2;
      else if (va || last_byte) pair.count = 2'd1;
      else pair.count = 2'd0;
   end

endmodule

/* hw/rtl/lud_rsp_stage.sv */
`timescale 1ns / 1ps

module lud_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  lud_pkg::pair_type new_pair,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output lud_pkg::res_type  rsp_res,
   output logic              free
);

   logic              valid_ff, valid_in;
   logic              sel_ff, sel_in;
   lud_pkg::pair_type pair_ff, pair_in;
   logic              two;

   assign two       = (pair_ff.count == 2'd2);
   assign rsp_valid = valid_ff;
   assign rsp_res   = sel_ff ? pair_ff.r1 : pair_ff.r0;
   // The stage frees up on the word that ends the current pair.
   assign free      = !valid_ff || (rsp_ready && (sel_ff || !two));

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      pair_in  = pair_ff;
      if (load) begin
         valid_in = 1'b1;
         sel_in   = 1'b0;
         pair_in  = new_pair;
      end else if (valid_ff && rsp_ready) begin
         if (!sel_ff && two) sel_in = 1'b1;
         else valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
      pair_ff <= pair_in;
   end

endmodule

/* hw/rtl/lenient_utf8_decoder_core.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Word
// req      in         req_valid/req_ready    data_byte, last_byte
// rsp      out        rsp_valid/rsp_ready    code_point, point_valid, point_index,
//                                            end_of_string, last_of_run
//
// A byte goes through an input register, the decode logic and a result register;
// its words reach rsp once the result register is free to load them.
// One byte per cycle is taken while each byte yields at most one word and rsp does not
// stall; a word-yielding byte after a two-word byte waits until the second word leaves.
// Reset clears the handshake state and all decode state; no clearing pass is needed.
// A stall on rsp backs up through the result register into req_ready.

`include "lenient_utf8_decoder_core_macros.svh"

module lenient_utf8_decoder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lud_pkg::CpBits-1:0]     rsp_code_point,
   output logic                           rsp_point_valid,
   output logic [lud_pkg::IdxOutBits-1:0] rsp_point_index,
   output logic                           rsp_end_of_string,
   output logic                           rsp_last_of_run
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   lud_pkg::state_type state_ff, state_in;
   lud_pkg::pair_type  pair;
   lud_pkg::res_type   res;
   logic               free;
   logic               move;
   logic               load;

   lud_decode u_decode (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt_state (state_in),
      .pair      (pair)
   );

   // Bytes that yield no word pass on without waiting for the result register.
   assign move      = in_valid_ff && (pair.count == 2'd0 || free);
   assign load      = move && (pair.count != 2'd0);
   assign req_ready = !in_valid_ff || move;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !move);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (move) state_ff <= state_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   lud_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .new_pair  (pair),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_res   (res),
      .free      (free)
   );

   assign rsp_code_point    = res.code_point;
   assign rsp_point_valid   = res.point_valid;
   assign rsp_point_index   = res.point_index;
   assign rsp_end_of_string = res.end_of_string;
   assign rsp_last_of_run   = res.last_of_run;

   `LUD_ASSERT_ALWAYS(a_held_below_len,
      state_ff.seq_len == lud_pkg::LenStray || {1'b0, state_ff.held_count} < state_ff.seq_len,
      "held count reached sequence length")
   `LUD_ASSERT_ALWAYS(a_len_legal,
      state_ff.seq_len != lud_pkg::LenOne && state_ff.seq_len <= lud_pkg::LenFour,
      "illegal open sequence length")
   `LUD_ASSERT_ALWAYS(a_eos_ends_run,
      !rsp_valid || !rsp_end_of_string || rsp_last_of_run,
      "end of string word not last of run")
   `LUD_ASSERT_ALWAYS(a_invalid_zero,
      !rsp_valid || rsp_point_valid || rsp_code_point == '0,
      "code point set on word without a point")
   `LUD_ASSERT_NEXT(a_string_clears, move && in_last_ff,
      state_ff.seq_len == lud_pkg::LenStray && state_ff.counter == '0,
      "state not cleared after last byte")

endmodule
